// File: rtl/pcc_pkg.sv
`default_nettype none

package pcc_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int MAX_PAIRS   = 65536;

    localparam int COUNT_W = $clog2(MAX_PAIRS + 1);
    localparam int SUM_W   = SAMPLE_BITS + COUNT_W - 1;
    localparam int SQ_W    = 2 * SAMPLE_BITS + COUNT_W - 2;
    localparam int XY_W    = SQ_W + 1;

    localparam int DIGIT_W   = 16;
    localparam int MAG_W     = ((COUNT_W + SQ_W + DIGIT_W - 1) / DIGIT_W) * DIGIT_W;
    localparam int SW        = MAG_W + 2;
    localparam int MUL_STEPS = MAG_W / DIGIT_W;
    localparam int STEP_W    = $clog2(MUL_STEPS);
    localparam int PROD_W    = 2 * MAG_W;

    localparam int FRAC_BITS  = 15;
    localparam int COEF_W     = FRAC_BITS + 1;
    localparam int DIV_STEPS  = 2 * FRAC_BITS + 1;
    localparam int QUOT_W     = DIV_STEPS;
    localparam int SQRT_STEPS = FRAC_BITS + 1;
    localparam int ROOT_W     = SQRT_STEPS;
    localparam int RAD_W      = 2 * SQRT_STEPS;
    localparam int SREM_W     = ROOT_W + 4;
    localparam int CNT_W      = $clog2(DIV_STEPS);

    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_PAIRS);
    localparam logic [QUOT_W-1:0]  QUOT_MAX  = {1'b1, {(2 * FRAC_BITS){1'b0}}};
    localparam logic [ROOT_W-1:0]  ROOT_ONE  = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [COEF_W-1:0]  COEF_MAX  = {1'b0, {FRAC_BITS{1'b1}}};

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_DEGEN = 2'd1,
        STAT_OVF   = 2'd2
    } status_t;

    localparam int OP_W = 3;

    typedef enum logic [OP_W-1:0] {
        OP_N_SXY,
        OP_SX_SY,
        OP_N_SXX,
        OP_SX_SX,
        OP_N_SYY,
        OP_SY_SY,
        OP_VX_VY,
        OP_A_A
    } mul_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIN,
        S_MUL_GO,
        S_MUL_WAIT,
        S_CHECK,
        S_DIV,
        S_SQRT_INIT,
        S_SQRT,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic    accept;
        logic    mul_start;
        logic    store;
        mul_op_t op;
        logic    div_step;
        logic    sqrt_init;
        logic    sqrt_step;
        logic    emit;
        status_t code;
    } dp_cmd_t;

    typedef struct packed {
        logic ovf;
        logic degenerate;
        logic mul_done;
    } dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/pcc_mult.sv
`default_nettype none

module pcc_mult (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [pcc_pkg::MAG_W-1:0]    a,
    input  logic [pcc_pkg::MAG_W-1:0]    b,
    output logic [pcc_pkg::PROD_W-1:0]   product,
    output logic                         done
);
    import pcc_pkg::*;

    logic [MAG_W-1:0]         a_reg;
    logic [MAG_W-1:0]         b_reg;
    logic [PROD_W-1:0]        acc_reg;
    logic [PROD_W-1:0]        acc_next;
    logic [STEP_W-1:0]        step_reg;
    logic                     run_reg;
    logic                     done_reg;
    logic [MAG_W+DIGIT_W-1:0] pp;

    // one 64x16 partial product per cycle, accumulator shifts right a digit
    assign pp = {{DIGIT_W{1'b0}}, a_reg} * {{MAG_W{1'b0}}, b_reg[DIGIT_W-1:0]};
    assign acc_next = (acc_reg >> DIGIT_W)
                    + {pp, {(PROD_W - MAG_W - DIGIT_W){1'b0}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg  <= 1'b1;
                step_reg <= '0;
            end
            else if (run_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(MUL_STEPS - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (run_reg)
        begin
            b_reg   <= b_reg >> DIGIT_W;
            acc_reg <= acc_next;
        end
    end

    assign product = acc_reg;
    assign done    = done_reg;

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !run_reg)
        else $error("multiplier started while running");

endmodule

`default_nettype wire

// File: rtl/pcc_datapath.sv
`default_nettype none

module pcc_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic signed [pcc_pkg::SAMPLE_BITS-1:0] x_sample,
    input  logic signed [pcc_pkg::SAMPLE_BITS-1:0] y_sample,
    input  pcc_pkg::dp_cmd_t                    cmd,
    output pcc_pkg::dp_stat_t                   st,
    output logic signed [pcc_pkg::COEF_W-1:0]   coefficient,
    output logic [1:0]                          status,
    output logic [pcc_pkg::COUNT_W-1:0]         pair_count,
    output logic                                done
);
    import pcc_pkg::*;

    // running sums
    logic [COUNT_W-1:0] count_reg;
    logic [SUM_W-1:0]   sx_reg;
    logic [SUM_W-1:0]   sy_reg;
    logic [SQ_W-1:0]    sxx_reg;
    logic [SQ_W-1:0]    syy_reg;
    logic [XY_W-1:0]    sxy_reg;
    logic               ovf_reg;
    logic               done_reg;

    logic signed [2*SAMPLE_BITS-1:0] xx;
    logic signed [2*SAMPLE_BITS-1:0] yy;
    logic signed [2*SAMPLE_BITS-1:0] xy;

    // finishing datapath
    logic [MAG_W-1:0]  opa;
    logic [MAG_W-1:0]  opb;
    logic              opneg;
    logic              neg_reg;
    logic [PROD_W-1:0] mul_prod;
    logic              mul_done;

    logic [SUM_W-1:0] sx_mag;
    logic [SUM_W-1:0] sy_mag;
    logic [XY_W-1:0]  sxy_mag;

    logic [SW-1:0] t_reg;
    logic [SW-1:0] ext;
    logic [SW-1:0] sv;
    logic [SW-1:0] diff;
    logic [SW-1:0] diff_mag;

    logic [MAG_W-1:0]  num_mag_reg;
    logic              num_neg_reg;
    logic [MAG_W-1:0]  vx_reg;
    logic [MAG_W-1:0]  vy_reg;
    logic [PROD_W-1:0] p_reg;

    logic [PROD_W-1:0] rem_reg;
    logic [PROD_W-1:0] rem_next;
    logic [PROD_W-1:0] div_trial;
    logic              din_reg;
    logic              div_ge;
    logic [QUOT_W-1:0] quot_reg;

    logic [RAD_W-1:0]  rad_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [SREM_W-1:0] srem_reg;
    logic [SREM_W-1:0] srem_sh;
    logic [SREM_W-1:0] srem_next;
    logic [SREM_W-1:0] sq_trial;
    logic              sq_ge;

    logic [COEF_W-1:0]  coef_reg;
    logic [COEF_W-1:0]  coef_next;
    status_t            status_reg;
    logic [COUNT_W-1:0] pcount_reg;

    assign xx = (2*SAMPLE_BITS)'(x_sample) * (2*SAMPLE_BITS)'(x_sample);
    assign yy = (2*SAMPLE_BITS)'(y_sample) * (2*SAMPLE_BITS)'(y_sample);
    assign xy = (2*SAMPLE_BITS)'(x_sample) * (2*SAMPLE_BITS)'(y_sample);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sx_reg    <= '0;
            sy_reg    <= '0;
            sxx_reg   <= '0;
            syy_reg   <= '0;
            sxy_reg   <= '0;
            ovf_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.emit;
            if (cmd.emit)
            begin
                count_reg <= '0;
                sx_reg    <= '0;
                sy_reg    <= '0;
                sxx_reg   <= '0;
                syy_reg   <= '0;
                sxy_reg   <= '0;
                ovf_reg   <= 1'b0;
            end
            else if (cmd.accept)
            begin
                if (count_reg == COUNT_MAX)
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    count_reg <= count_reg + COUNT_W'(1);
                    sx_reg  <= sx_reg
                             + {{(SUM_W - SAMPLE_BITS){x_sample[SAMPLE_BITS-1]}}, x_sample};
                    sy_reg  <= sy_reg
                             + {{(SUM_W - SAMPLE_BITS){y_sample[SAMPLE_BITS-1]}}, y_sample};
                    sxx_reg <= sxx_reg + {{(SQ_W - 2*SAMPLE_BITS){1'b0}}, xx};
                    syy_reg <= syy_reg + {{(SQ_W - 2*SAMPLE_BITS){1'b0}}, yy};
                    sxy_reg <= sxy_reg
                             + {{(XY_W - 2*SAMPLE_BITS){xy[2*SAMPLE_BITS-1]}}, xy};
                end
            end
        end
    end

    assign sx_mag  = sx_reg[SUM_W-1]  ? (~sx_reg + SUM_W'(1))  : sx_reg;
    assign sy_mag  = sy_reg[SUM_W-1]  ? (~sy_reg + SUM_W'(1))  : sy_reg;
    assign sxy_mag = sxy_reg[XY_W-1] ? (~sxy_reg + XY_W'(1)) : sxy_reg;

    always_comb
    begin
        opa   = '0;
        opb   = '0;
        opneg = 1'b0;
        unique case (cmd.op)
            OP_N_SXY:
            begin
                opa   = MAG_W'(count_reg);
                opb   = MAG_W'(sxy_mag);
                opneg = sxy_reg[XY_W-1];
            end
            OP_SX_SY:
            begin
                opa   = MAG_W'(sx_mag);
                opb   = MAG_W'(sy_mag);
                opneg = sx_reg[SUM_W-1] ^ sy_reg[SUM_W-1];
            end
            OP_N_SXX:
            begin
                opa = MAG_W'(count_reg);
                opb = MAG_W'(sxx_reg);
            end
            OP_SX_SX:
            begin
                opa = MAG_W'(sx_mag);
                opb = MAG_W'(sx_mag);
            end
            OP_N_SYY:
            begin
                opa = MAG_W'(count_reg);
                opb = MAG_W'(syy_reg);
            end
            OP_SY_SY:
            begin
                opa = MAG_W'(sy_mag);
                opb = MAG_W'(sy_mag);
            end
            OP_VX_VY:
            begin
                opa = vx_reg;
                opb = vy_reg;
            end
            OP_A_A:
            begin
                opa = num_mag_reg;
                opb = num_mag_reg;
            end
            default:
            begin
                opa = '0;
            end
        endcase
    end

    pcc_mult u_mult (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.mul_start),
        .a       (opa),
        .b       (opb),
        .product (mul_prod),
        .done    (mul_done)
    );

    // signed view of the product, difference against the held first term
    assign ext      = {2'b00, mul_prod[MAG_W-1:0]};
    assign sv       = neg_reg ? (~ext + SW'(1)) : ext;
    assign diff     = t_reg - sv;
    assign diff_mag = diff[SW-1] ? (~diff + SW'(1)) : diff;

    // restoring divide: a^2 * 2^30 / (vx * vy)
    assign div_trial = {rem_reg[PROD_W-2:0], din_reg};
    assign div_ge    = (div_trial >= p_reg);
    assign rem_next  = div_ge ? (div_trial - p_reg) : div_trial;

    // integer square root, two radicand bits a step
    assign srem_sh   = {srem_reg[SREM_W-3:0], rad_reg[RAD_W-1 -: 2]};
    assign sq_trial  = {2'b00, root_reg, 2'b01};
    assign sq_ge     = (srem_sh >= sq_trial);
    assign srem_next = sq_ge ? (srem_sh - sq_trial) : srem_sh;

    always_ff @(posedge clk)
    begin
        if (cmd.mul_start)
        begin
            neg_reg <= opneg;
        end
        if (cmd.store)
        begin
            unique case (cmd.op)
                OP_N_SXY, OP_N_SXX, OP_N_SYY:
                begin
                    t_reg <= sv;
                end
                OP_SX_SY:
                begin
                    num_neg_reg <= diff[SW-1];
                    num_mag_reg <= diff_mag[MAG_W-1:0];
                end
                OP_SX_SX:
                begin
                    vx_reg <= diff[MAG_W-1:0];
                end
                OP_SY_SY:
                begin
                    vy_reg <= diff[MAG_W-1:0];
                end
                OP_VX_VY:
                begin
                    p_reg <= mul_prod;
                end
                OP_A_A:
                begin
                    rem_reg  <= mul_prod >> 1;
                    din_reg  <= mul_prod[0];
                    quot_reg <= '0;
                end
                default:
                begin
                    t_reg <= sv;
                end
            endcase
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= rem_next;
            din_reg  <= 1'b0;
            quot_reg <= {quot_reg[QUOT_W-2:0], div_ge};
        end
        if (cmd.sqrt_init)
        begin
            rad_reg  <= RAD_W'(quot_reg);
            root_reg <= '0;
            srem_reg <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            rad_reg  <= rad_reg << 2;
            root_reg <= {root_reg[ROOT_W-2:0], sq_ge};
            srem_reg <= srem_next;
        end
    end

    always_comb
    begin
        case (cmd.code)
            STAT_OK:
            begin
                if (num_neg_reg)
                begin
                    coef_next = ~root_reg + ROOT_W'(1);
                end
                else if (root_reg == ROOT_ONE)
                begin
                    coef_next = COEF_MAX;
                end
                else
                begin
                    coef_next = root_reg;
                end
            end
            default:
            begin
                coef_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            coef_reg   <= coef_next;
            status_reg <= cmd.code;
            pcount_reg <= count_reg;
        end
    end

    assign st.ovf        = ovf_reg;
    assign st.degenerate = (vx_reg == '0) || (vy_reg == '0);
    assign st.mul_done   = mul_done;

    assign coefficient = $signed(coef_reg);
    assign status      = status_reg;
    assign pair_count  = pcount_reg;
    assign done        = done_reg;

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> (rem_reg < p_reg))
        else $error("divider remainder not below divisor");

    a_quot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sqrt_init |-> (quot_reg <= QUOT_MAX))
        else $error("quotient exceeds unit correlation");

endmodule

`default_nettype wire

// File: rtl/pcc_ctrl.sv
`default_nettype none

module pcc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              last,
    input  pcc_pkg::dp_stat_t st,
    output pcc_pkg::dp_cmd_t  cmd,
    output logic              busy
);
    import pcc_pkg::*;

    state_t            state_reg;
    state_t            state_next;
    mul_op_t           op_reg;
    mul_op_t           op_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    status_t           code_reg;
    status_t           code_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_N_SXY;
            cnt_reg   <= '0;
            code_reg  <= STAT_OK;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            cnt_reg   <= cnt_next;
            code_reg  <= code_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cnt_next   = cnt_reg;
        code_next  = code_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start && last)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (st.ovf)
                begin
                    code_next  = STAT_OVF;
                    state_next = S_EMIT;
                end
                else
                begin
                    op_next    = OP_N_SXY;
                    state_next = S_MUL_GO;
                end
            end
            S_MUL_GO:
            begin
                state_next = S_MUL_WAIT;
            end
            S_MUL_WAIT:
            begin
                if (st.mul_done)
                begin
                    if (op_reg == OP_SY_SY)
                    begin
                        state_next = S_CHECK;
                    end
                    else if (op_reg == OP_A_A)
                    begin
                        cnt_next   = CNT_W'(DIV_STEPS - 1);
                        state_next = S_DIV;
                    end
                    else
                    begin
                        op_next    = mul_op_t'(op_reg + OP_W'(1));
                        state_next = S_MUL_GO;
                    end
                end
            end
            S_CHECK:
            begin
                if (st.degenerate)
                begin
                    code_next  = STAT_DEGEN;
                    state_next = S_EMIT;
                end
                else
                begin
                    op_next    = OP_VX_VY;
                    state_next = S_MUL_GO;
                end
            end
            S_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = S_SQRT_INIT;
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            S_SQRT_INIT:
            begin
                cnt_next   = CNT_W'(SQRT_STEPS - 1);
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                if (cnt_reg == '0)
                begin
                    code_next  = STAT_OK;
                    state_next = S_EMIT;
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            S_EMIT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                busy       = 1'b0;
                cmd.accept = start;
            end
            S_MUL_GO:
            begin
                cmd.mul_start = 1'b1;
                cmd.op        = op_reg;
            end
            S_MUL_WAIT:
            begin
                cmd.store = st.mul_done;
                cmd.op    = op_reg;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            S_SQRT_INIT:
            begin
                cmd.sqrt_init = 1'b1;
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
            end
            S_EMIT:
            begin
                cmd.emit = 1'b1;
                cmd.code = code_reg;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/pearson_correlation_core.sv
// Pearson correlation core. Sample pairs are taken one per clock while busy is low
// (start high); the pair with last set closes the data set and raises busy. The
// coefficient (Q1.15, rounded toward zero, +1 shown as 32767) then appears for a single
// cycle with done, after eight products on the shared 64x16 iterative multiplier, a
// 31-step restoring divider and a 16-step square root. A set with zero variance or an
// overflowed set skips the rest and reports with a zero coefficient and its status code.
// Busy is already low while done is high, so the next set can start in that cycle. done
// cannot be held off: the receiver must take each result beat as it comes.
`default_nettype none

module pearson_correlation_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic signed [pcc_pkg::SAMPLE_BITS-1:0] x_sample,
    input  logic signed [pcc_pkg::SAMPLE_BITS-1:0] y_sample,
    input  logic                                   last,
    output logic                                   busy,
    output logic                                   done,
    output logic signed [pcc_pkg::COEF_W-1:0]      coefficient,
    output logic [1:0]                             status,
    output logic [pcc_pkg::COUNT_W-1:0]            pair_count
);
    import pcc_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t st;

    pcc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .last  (last),
        .st    (st),
        .cmd   (cmd),
        .busy  (busy)
    );

    pcc_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .x_sample    (x_sample),
        .y_sample    (y_sample),
        .cmd         (cmd),
        .st          (st),
        .coefficient (coefficient),
        .status      (status),
        .pair_count  (pair_count),
        .done        (done)
    );

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while still busy");

endmodule

`default_nettype wire
